>>> rtl/core/pcmf_pkg.sv
// Package for the PCM to float converter: payload structs, format codes.
// No dependencies.
`default_nettype none
package pcmf_pkg;
	typedef enum logic [1:0] {
		FMT_S16 = 2'd0,
		FMT_S24 = 2'd1,
		FMT_S32 = 2'd2,
		FMT_BAD = 2'd3
	} fmt_t;

	typedef struct packed {
		logic [31:0] sample_word;
		logic        last_in;
	} in_item_t;

	typedef struct packed {
		logic [31:0] float_bits;
		logic        last_out;
	} out_item_t;

	// Exponent bias offset per format: 127 - (n-1)
	localparam logic [7:0] BIAS_S16 = 8'd112;
	localparam logic [7:0] BIAS_S24 = 8'd104;
	localparam logic [7:0] BIAS_S32 = 8'd96;
endpackage
`default_nettype wire

>>> rtl/core/pcmf_norm.sv
// Leading-one detect and left-normalize of a 32-bit magnitude, two stages.
// Depends on pcmf_pkg.
`default_nettype none
module pcmf_norm import pcmf_pkg::*; (
	input  wire logic        clk,
	input  wire logic        adv,
	input  wire logic [31:0] mag,
	output logic      [31:0] norm,
	output logic      [4:0]  pos
);
	logic [31:0] half_s1;
	logic [4:0]  pos_s1;
	logic [31:0] norm_q;
	logic [4:0]  pos_q;
	logic [31:0] t;
	logic [4:0]  p;

	// Coarse shift by 16 and 8
	always_comb begin
		t = mag;
		p = 5'd31;
		if (t[31:16] == 16'd0) begin
			t = {t[15:0], 16'd0};
			p = p - 5'd16;
		end
		if (t[31:24] == 8'd0) begin
			t = {t[23:0], 8'd0};
			p = p - 5'd8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			half_s1 <= t;
			pos_s1  <= p;
		end
	end

	logic [31:0] u;
	logic [4:0]  r;
	// Fine shift by 4, 2, 1
	always_comb begin
		u = half_s1;
		r = pos_s1;
		if (u[31:28] == 4'd0) begin
			u = {u[27:0], 4'd0};
			r = r - 5'd4;
		end
		if (u[31:30] == 2'd0) begin
			u = {u[29:0], 2'd0};
			r = r - 5'd2;
		end
		if (!u[31]) begin
			u = {u[30:0], 1'b0};
			r = r - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			norm_q <= u;
			pos_q  <= r;
		end
	end

	assign norm = norm_q;
	assign pos  = pos_q;
endmodule
`default_nettype wire

>>> rtl/core/pcm_to_float_converter.sv
// Throughput: one sample per cycle; a stall holds every stage in place.
// Stages: sign extract, coarse normalize, fine normalize, round and pack.
// Reset clears the stage valid bits and sets the format register fmt_q to 16-bit.
// Depends on pcmf_pkg and pcmf_norm.
`default_nettype none
module pcm_to_float_converter import pcmf_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cfg_we,
	input  wire logic [1:0] cfg_wdata,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_data
);
	logic [1:0] fmt_q;
	logic       v_s1, v_s2, v_s3, v_s4;
	logic       adv;

	// Whole pipe advances unless the output holds a result not taken
	assign adv      = !v_s4 || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fmt_q <= FMT_S16;
		else if (cfg_we) fmt_q <= cfg_wdata;
	end

	// Stage 1: pick width, sign, magnitude
	logic [31:0] x, mag;
	logic        neg, bad;
	logic [7:0]  bias;
	always_comb begin
		x = 32'd0; neg = 1'b0; bias = BIAS_S16; bad = 1'b0;
		unique case (fmt_t'(fmt_q))
			FMT_S16: begin
				x = {{16{in_data.sample_word[15]}}, in_data.sample_word[15:0]};
				bias = BIAS_S16;
			end
			FMT_S24: begin
				x = {{8{in_data.sample_word[23]}}, in_data.sample_word[23:0]};
				bias = BIAS_S24;
			end
			FMT_S32: begin
				x = in_data.sample_word;
				bias = BIAS_S32;
			end
			default: bad = 1'b1;
		endcase
		neg = x[31];
		mag = neg ? (~x + 32'd1) : x;
	end

	logic [31:0] mag_s1;
	logic        neg_s1, zero_s1, last_s1;
	logic [7:0]  bias_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s1  <= mag;
			neg_s1  <= neg;
			zero_s1 <= bad || (x == 32'd0);
			bias_s1 <= bias;
			last_s1 <= in_data.last_in;
		end
	end

	logic [31:0] norm;
	logic [4:0]  pos;
	pcmf_norm u_norm (
		.clk(clk), .adv(adv), .mag(mag_s1), .norm(norm), .pos(pos)
	);

	// Side data delayed alongside the normalizer
	logic neg_s2, zero_s2, last_s2, neg_s3, zero_s3, last_s3;
	logic [7:0] bias_s2, bias_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s2 <= neg_s1; zero_s2 <= zero_s1; last_s2 <= last_s1; bias_s2 <= bias_s1;
			neg_s3 <= neg_s2; zero_s3 <= zero_s2; last_s3 <= last_s2; bias_s3 <= bias_s2;
		end
	end

	// Stage 4: round nearest-even on the low 8 bits, pack
	logic [24:0] mant;
	logic        rnd;
	logic [7:0]  bexp;
	logic [31:0] bits;
	always_comb begin
		rnd  = norm[7] && (norm[6:0] != 7'd0 || norm[8]);
		mant = {1'b0, norm[31:8]} + {24'd0, rnd};
		bexp = {3'd0, pos} + bias_s3;
		if (mant[24]) begin
			mant = mant >> 1;
			bexp = bexp + 8'd1;
		end
		bits = zero_s3 ? 32'd0 : {neg_s3, bexp, mant[22:0]};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data.float_bits <= bits;
			out_data.last_out   <= last_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
		end
	end
	assign out_valid = v_s4;

	// Stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed under stall");
	// Accepted input reaches output stage via v_s2 and v_s3 when never stalled
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready ##1 adv ##1 adv ##1 adv |=> out_valid)
		else $error("transaction lost in pipe");
	// Zero flag yields +0.0
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		adv && v_s3 && zero_s3 |=> out_data.float_bits == 32'd0)
		else $error("zero not +0.0");
endmodule
`default_nettype wire
